### sv/indexed_palette_pixel_decoder_macros.svh
// Assertion macros used by the palette pixel decoder top level.
`ifndef INDEXED_PALETTE_PIXEL_DECODER_MACROS_SVH
`define INDEXED_PALETTE_PIXEL_DECODER_MACROS_SVH

// Condition that holds at every clock edge out of reset.
`define IPD_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent that holds in the same cycle as the antecedent.
`define IPD_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent that holds in the cycle after the antecedent.
`define IPD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### sv/ipd_pkg.sv
// Shared types and constants of the palette pixel decoder.
package ipd_pkg;

    localparam logic       ACT_PALETTE = 1'b0;
    localparam logic       ACT_IMAGE   = 1'b1;

    localparam logic [1:0] REG_NIBBLE_MODE  = 2'd0;
    localparam logic [1:0] REG_PALETTE_SIZE = 2'd1;
    localparam logic [1:0] REG_IMAGE_SIZE   = 2'd2;

    localparam logic [16:0] TOTAL_RESET = 17'd49152;

    localparam logic [4:0] CHANNEL_MASK = 5'h1F;
    localparam logic [3:0] NIBBLE_MASK  = 4'h0F;

    typedef struct packed {
        logic [15:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        write_pixel;
        logic        last;
    } result_t;

endpackage

### sv/ipd_ram.sv
// Generic single-port-write, registered-read RAM.
module ipd_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/ipd_out_fifo.sv
// Two-entry result queue in front of the output channel.
module ipd_out_fifo (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  ipd_pkg::result_t push_data,
    input  logic             pop,
    output logic [1:0]       count,
    output ipd_pkg::result_t head
);

    ipd_pkg::result_t entry_reg [2];
    logic             rd_ptr_reg;
    logic             rd_ptr_next;
    logic             wr_ptr_reg;
    logic             wr_ptr_next;
    logic [1:0]       count_reg;
    logic [1:0]       count_next;

    always_comb
    begin
        rd_ptr_next = pop  ? !rd_ptr_reg : rd_ptr_reg;
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= 1'b0;
            wr_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    assign count = count_reg;
    assign head  = entry_reg[rd_ptr_reg];

endmodule

### sv/indexed_palette_pixel_decoder.sv
// Top level of the indexed palette pixel decoder (RGB555 palette to RGB888 pixels).
//
//   Channel  Direction  Handshake               Carries
//   in       input      in_valid / in_stall     palette write or image byte
//   out      output     out_valid / out_stall   one RGB888 pixel with its position
//   cfg      input      cfg_valid / cfg_ready   register index and data
//
// A palette write or a byte-mode image byte is handled whole; a nibble-mode byte as its high, then its low nibble.
// The single read port of the palette RAM issues at most one pixel lookup per cycle.
// A lookup's result is registered in the RAM read register and then in the result queue before it reaches the output.
// Reset clears the counter and returns the registers to their defaults; palette entries
// hold nothing until written.
// A stalled output holds results in a two-entry queue; lookups wait for queue room.
`include "indexed_palette_pixel_decoder_macros.svh"

module indexed_palette_pixel_decoder #(
    parameter int PALETTE_DEPTH = 256,
    parameter int MAX_PIXELS    = 65536
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  palette_index,
    input  logic [15:0] palette_color,
    input  logic [7:0]  image_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel_index,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        write_pixel,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int AW = $clog2(PALETTE_DEPTH);

    logic        nibble_mode_reg;
    logic [8:0]  palette_size_reg;
    logic [16:0] image_size_reg;

    logic        active_reg;
    logic        phase_reg;
    logic        act_reg;
    logic [7:0]  pidx_reg;
    logic [14:0] pcol_reg;
    logic [7:0]  byte_reg;
    logic        lastb_reg;
    logic [16:0] counter_reg;
    logic [16:0] counter_next;

    logic        inflight_reg;
    logic [15:0] pend_index_reg;
    logic        pend_use_reg;
    logic        pend_wr_reg;
    logic        pend_last_reg;

    logic [8:0]  eff_count;
    logic [16:0] eff_total;
    logic [16:0] counter_inc;
    logic [2:0]  occupancy;
    logic        pop;
    logic        step;
    logic        is_image;
    logic        done;
    logic        pix_live;
    logic        issue;
    logic [3:0]  nib;
    logic        nib_zero;
    logic        nib_hit;
    logic        use_mem;
    logic        wr_flag;
    logic        last_flag;
    logic        in_accept;
    logic        ram_we;
    logic [AW-1:0] ram_raddr;
    logic [14:0] ram_rdata;
    logic [14:0] color;
    logic [1:0]  fifo_count;
    ipd_pkg::result_t push_data;
    ipd_pkg::result_t head;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_mode_reg  <= 1'b0;
            palette_size_reg <= 9'd0;
            image_size_reg   <= ipd_pkg::TOTAL_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ipd_pkg::REG_NIBBLE_MODE:  nibble_mode_reg  <= cfg_data[0];
                ipd_pkg::REG_PALETTE_SIZE: palette_size_reg <= cfg_data[8:0];
                ipd_pkg::REG_IMAGE_SIZE:   image_size_reg   <= cfg_data;
                default:                   nibble_mode_reg  <= nibble_mode_reg;
            endcase
        end
    end

    always_comb
    begin
        eff_count = (palette_size_reg > 9'(PALETTE_DEPTH)) ? 9'(PALETTE_DEPTH)
                                                           : palette_size_reg;
        eff_total = (image_size_reg > 17'(MAX_PIXELS)) ? 17'(MAX_PIXELS)
                                                       : image_size_reg;
        counter_inc = counter_reg + 17'd1;

        pop       = out_valid && !out_stall;
        occupancy = 3'(fifo_count) + 3'(inflight_reg);
        step      = active_reg && (occupancy < (3'd2 + 3'(pop)));

        is_image = (act_reg == ipd_pkg::ACT_IMAGE);
        done     = !is_image || !nibble_mode_reg || phase_reg;
        pix_live = counter_reg < eff_total;
        issue    = step && is_image && pix_live;

        nib      = (phase_reg ? byte_reg[3:0] : byte_reg[7:4]) & ipd_pkg::NIBBLE_MASK;
        nib_zero = (nib == 4'd0);
        nib_hit  = 9'(nib) < eff_count;

        if (nibble_mode_reg)
        begin
            use_mem   = !nib_zero && nib_hit;
            wr_flag   = nib_zero || nib_hit;
            last_flag = phase_reg || (counter_inc >= eff_total);
            ram_raddr = AW'(nib);
        end
        else
        begin
            use_mem   = 9'(byte_reg) < eff_count;
            wr_flag   = 1'b1;
            last_flag = 1'b1;
            ram_raddr = byte_reg[AW-1:0];
        end

        ram_we = step && !is_image && (9'(pidx_reg) < 9'(PALETTE_DEPTH));

        counter_next = counter_reg;
        if (step && is_image)
        begin
            if (done && lastb_reg)
            begin
                counter_next = 17'd0;
            end
            else if (pix_live)
            begin
                counter_next = counter_inc;
            end
        end

        in_stall  = active_reg && !(step && done);
        in_accept = in_valid && !in_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            phase_reg    <= 1'b0;
            counter_reg  <= 17'd0;
            inflight_reg <= 1'b0;
        end
        else
        begin
            counter_reg  <= counter_next;
            inflight_reg <= issue;
            if (in_accept)
            begin
                active_reg <= 1'b1;
                phase_reg  <= 1'b0;
            end
            else if (step)
            begin
                active_reg <= !done;
                phase_reg  <= !done;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            act_reg   <= action;
            pidx_reg  <= palette_index;
            pcol_reg  <= palette_color[14:0];
            byte_reg  <= image_byte;
            lastb_reg <= last_byte;
        end
        if (issue)
        begin
            pend_index_reg <= counter_reg[15:0];
            pend_use_reg   <= use_mem;
            pend_wr_reg    <= wr_flag;
            pend_last_reg  <= last_flag;
        end
    end

    ipd_ram #(
        .WIDTH (15),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .clk   (clk),
        .we    (ram_we),
        .waddr (pidx_reg[AW-1:0]),
        .wdata (pcol_reg),
        .re    (issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        color                 = pend_use_reg ? ram_rdata : 15'd0;
        push_data.pixel_index = pend_index_reg;
        push_data.red         = {color[4:0] & ipd_pkg::CHANNEL_MASK, 3'b000};
        push_data.green       = {color[9:5] & ipd_pkg::CHANNEL_MASK, 3'b000};
        push_data.blue        = {color[14:10] & ipd_pkg::CHANNEL_MASK, 3'b000};
        push_data.write_pixel = pend_wr_reg;
        push_data.last        = pend_last_reg;
    end

    ipd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (inflight_reg),
        .push_data (push_data),
        .pop       (pop),
        .count     (fifo_count),
        .head      (head)
    );

    assign out_valid   = (fifo_count != 2'd0);
    assign pixel_index = head.pixel_index;
    assign red         = head.red;
    assign green       = head.green;
    assign blue        = head.blue;
    assign write_pixel = head.write_pixel;
    assign last        = head.last;

    `IPD_ASSERT_ALWAYS(a_queue_room, occupancy <= 3'd2, "Result queue overcommitted.")
    `IPD_ASSERT_IMPLY(a_idle_ready, !active_reg, !in_stall, "Input stalled while empty.")
    `IPD_ASSERT_NEXT(a_second_nibble_ends, step && phase_reg, !phase_reg, "Byte overran.")
    `IPD_ASSERT_IMPLY(a_skip_only_nibble, out_valid && !write_pixel, nibble_mode_reg, "Byte skip.")

endmodule

### bench/tb.sv
// Testbench for the indexed palette pixel decoder: scoreboard class, drivers and stimulus.
module tb;

    class pixel_scoreboard;
        logic        nibble_mode;
        logic [8:0]  palette_size;
        logic [16:0] image_size;
        logic [14:0] palette [256];
        int unsigned pixel_counter;
        ipd_pkg::result_t pixels_due [$];
        int unsigned requests;
        int unsigned pixels_seen;
        int unsigned errors;

        function new();
            nibble_mode   = 1'b0;
            palette_size  = '0;
            image_size    = ipd_pkg::TOTAL_RESET;
            pixel_counter = 0;
            requests      = 0;
            pixels_seen   = 0;
            errors        = 0;
        endfunction

        function void write_reg(logic [1:0] index, logic [16:0] data);
            case (index)
                ipd_pkg::REG_NIBBLE_MODE:  nibble_mode  = data[0];
                ipd_pkg::REG_PALETTE_SIZE: palette_size = data[8:0];
                ipd_pkg::REG_IMAGE_SIZE:   image_size   = data;
                default: ;
            endcase
        endfunction

        function int unsigned live_colors();
            return (palette_size > 9'd256) ? 256 : 32'(palette_size);
        endfunction

        function void queue_pixel(logic [14:0] color, logic wr);
            ipd_pkg::result_t px;
            px.pixel_index = pixel_counter[15:0];
            px.red         = {color[4:0], 3'b000};
            px.green       = {color[9:5], 3'b000};
            px.blue        = {color[14:10], 3'b000};
            px.write_pixel = wr;
            px.last        = 1'b0;
            pixels_due.push_back(px);
            pixel_counter++;
        endfunction

        function void note_request(logic act, logic [7:0] pidx, logic [15:0] pcol,
                                   logic [7:0] img, logic lastb);
            int unsigned colors;
            int unsigned limit;
            int unsigned first;
            logic [3:0]  idx;
            requests++;
            if (act == ipd_pkg::ACT_PALETTE)
            begin
                palette[pidx] = pcol[14:0];
                return;
            end
            colors = live_colors();
            limit  = (image_size > 17'd65536) ? 65536 : 32'(image_size);
            first  = pixels_due.size();
            if (!nibble_mode)
            begin
                if (pixel_counter < limit)
                    queue_pixel((img < colors) ? palette[img] : 15'd0, 1'b1);
            end
            else
            begin
                for (int k = 0; k < 2; k++)
                begin
                    idx = (k == 0) ? img[7:4] : img[3:0];
                    if (pixel_counter < limit)
                    begin
                        if (idx == 4'd0)
                            queue_pixel(15'd0, 1'b1);
                        else if (idx < colors)
                            queue_pixel(palette[idx], 1'b1);
                        else
                            queue_pixel(15'd0, 1'b0);
                    end
                end
            end
            if (pixels_due.size() > first)
                pixels_due[pixels_due.size() - 1].last = 1'b1;
            if (lastb)
                pixel_counter = 0;
        endfunction

        function void field_check(string name, logic [15:0] want, logic [15:0] got);
            if (want !== got)
            begin
                errors++;
                $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(ipd_pkg::result_t got);
            ipd_pkg::result_t want;
            if (pixels_due.size() == 0)
            begin
                errors++;
                $display("%0t: pixel %0h arrived with none expected", $time, got.pixel_index);
                return;
            end
            want = pixels_due.pop_front();
            pixels_seen++;
            field_check("pixel_index", want.pixel_index, got.pixel_index);
            field_check("red", 16'(want.red), 16'(got.red));
            field_check("green", 16'(want.green), 16'(got.green));
            field_check("blue", 16'(want.blue), 16'(got.blue));
            field_check("write_pixel", 16'(want.write_pixel), 16'(got.write_pixel));
            field_check("last", 16'(want.last), 16'(got.last));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  palette_index;
    logic [15:0] palette_color;
    logic [7:0]  image_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        write_pixel;
    logic        last;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [16:0] cfg_data;

    pixel_scoreboard sb = new();
    bit          written [256];
    logic [7:0]  loaded [$];
    int unsigned gap_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned reg_writes = 0;

    indexed_palette_pixel_decoder dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #(12 * 400000);
        $display("indexed_palette_pixel_decoder test failed");
        $finish;
    end

    function automatic int unsigned pause_len();
        return ($urandom_range(9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
    endfunction

    function automatic bit safe_index(logic [7:0] idx, int unsigned colors);
        return idx >= colors || written[idx];
    endfunction

    function automatic logic [7:0] pick_image_byte();
        logic [7:0]  b;
        int unsigned colors;
        colors = sb.live_colors();
        if (!sb.nibble_mode && loaded.size() != 0 && $urandom_range(1) == 0)
            return loaded[$urandom_range(loaded.size() - 1)];
        for (int t = 0; t < 64; t++)
        begin
            b = 8'($urandom);
            if (sb.nibble_mode ? (safe_index({4'd0, b[7:4]}, colors) &&
                                  safe_index({4'd0, b[3:0]}, colors))
                               : safe_index(b, colors))
                return b;
        end
        return sb.nibble_mode ? 8'h00 : loaded[0];
    endfunction

    always @(posedge clk)
    begin : monitors
        ipd_pkg::result_t got;
        if (rst_n && in_valid && !in_stall)
            sb.note_request(action, palette_index, palette_color, image_byte, last_byte);
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{pixel_index, red, green, blue, write_pixel, last};
            sb.check_result(got);
        end
    end

    initial
    begin : output_backpressure
        int unsigned hold;
        hold = 0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold != 0)
                hold--;
            else if ($urandom_range(99) < stall_pct)
            begin
                out_stall <= 1'b1;
                hold = pause_len();
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_request(logic act, logic [7:0] pidx, logic [15:0] pcol,
                                logic [7:0] img, logic lastb);
        int unsigned gap;
        in_valid      <= 1'b1;
        action        <= act;
        palette_index <= pidx;
        palette_color <= pcol;
        image_byte    <= img;
        last_byte     <= lastb;
        do @(posedge clk); while (in_stall);
        gap = ($urandom_range(99) < gap_pct) ? pause_len() : 0;
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic load_entry(logic [7:0] idx, logic [15:0] color);
        if (!written[idx])
            loaded.push_back(idx);
        written[idx] = 1'b1;
        send_request(ipd_pkg::ACT_PALETTE, idx, color, 8'($urandom), 1'($urandom));
    endtask

    task automatic send_pixels(logic [7:0] img, logic lastb);
        send_request(ipd_pkg::ACT_IMAGE, 8'($urandom), 16'($urandom), img, lastb);
    endtask

    // Hold off new requests until every expected pixel is out and the pipeline is empty.
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pixels_due.size() != 0) @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic set_register(logic [1:0] idx, logic [16:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.write_reg(idx, data);
        reg_writes++;
    endtask

    initial
    begin : stimulus
        logic [16:0] value;
        int unsigned burst;
        int unsigned pause_at;
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        action        <= ipd_pkg::ACT_PALETTE;
        palette_index <= '0;
        palette_color <= '0;
        image_byte    <= '0;
        last_byte     <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_index     <= ipd_pkg::REG_NIBBLE_MODE;
        cfg_data      <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        gap_pct   = 30;
        stall_pct = 30;
        send_pixels(8'hFF, 1'b0);
        send_pixels(8'h00, 1'b0);
        load_entry(8'd0, 16'hFFFF);
        load_entry(8'd255, 16'hFC1F);
        for (int i = 1; i < 16; i++)
            load_entry(8'(i), 16'($urandom));
        set_register(ipd_pkg::REG_PALETTE_SIZE, 17'd256);
        send_pixels(8'hFF, 1'b0);
        send_pixels(8'h00, 1'b0);
        send_pixels(8'h0F, 1'b0);
        set_register(ipd_pkg::REG_PALETTE_SIZE, 17'h1FFFF);
        send_pixels(8'hFF, 1'b0);
        set_register(ipd_pkg::REG_NIBBLE_MODE, 17'd1);
        set_register(ipd_pkg::REG_PALETTE_SIZE, 17'd5);
        send_pixels(8'h04, 1'b0);
        send_pixels(8'h5F, 1'b0);
        set_register(ipd_pkg::REG_IMAGE_SIZE, 17'd3);
        send_pixels(8'h12, 1'b1);
        send_pixels(8'h31, 1'b0);
        send_pixels(8'h42, 1'b1);
        set_register(ipd_pkg::REG_IMAGE_SIZE, 17'h1FFFF);
        send_pixels(8'hF0, 1'b1);
        set_register(ipd_pkg::REG_IMAGE_SIZE, 17'd0);
        send_pixels(8'h11, 1'b1);

        for (int ph = 0; ph < 9; ph++)
        begin
            case ($urandom_range(2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 50;
            endcase
            case ($urandom_range(2))
                0: stall_pct = 0;
                1: stall_pct = 15;
                default: stall_pct = 50;
            endcase
            if (ph == 0)
            begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            set_register(ipd_pkg::REG_NIBBLE_MODE, 17'($urandom));
            value = 17'($urandom);
            case ($urandom_range(5))
                0: value[8:0] = 9'd0;
                1: value[8:0] = 9'($urandom_range(1, 15));
                2: value[8:0] = 9'd16;
                3: value[8:0] = 9'd256;
                4: value[8:0] = 9'($urandom_range(257, 511));
                default: value[8:0] = 9'($urandom_range(255));
            endcase
            set_register(ipd_pkg::REG_PALETTE_SIZE, value);
            case ($urandom_range(4))
                0: value = 17'($urandom_range(3));
                1: value = 17'($urandom_range(4, 60));
                2: value = 17'd65536;
                3: value = 17'($urandom_range(65537, 131071));
                default: value = 17'($urandom);
            endcase
            set_register(ipd_pkg::REG_IMAGE_SIZE, value);
            burst = $urandom_range(4, 12);
            repeat (burst) load_entry(8'($urandom), 16'($urandom));
            pause_at = $urandom_range(10, 40);
            for (int n = 0; n < 50; n++)
            begin
                if (n == pause_at)
                    settle();
                if ($urandom_range(99) < 15)
                    load_entry(8'($urandom), 16'($urandom));
                else
                    send_pixels(pick_image_byte(), $urandom_range(11) == 0);
            end
        end

        settle();
        $display("Run summary: %0d requests accepted, %0d pixels checked, %0d register writes.",
                 sb.requests, sb.pixels_seen, reg_writes);
        $display("Byte and nibble modes ran with random request gaps and output stalls.");
        if (sb.errors == 0 && sb.pixels_due.size() == 0)
            $display("indexed_palette_pixel_decoder test passed");
        else
            $display("indexed_palette_pixel_decoder test failed");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/ipd_pkg.sv
sv/ipd_ram.sv
sv/ipd_out_fifo.sv
sv/indexed_palette_pixel_decoder.sv
bench/tb.sv
